// ===== rtl/core/rtt_aimd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rtt_aimd_pkg;

    localparam int unsigned RTT_W   = 20;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned DEPTH_W = 8;
    localparam int unsigned DATA_W  = 56;

    localparam logic [TIME_W-1:0]  NUDGE_INTERVAL_MS = 32'd400;
    localparam logic [RTT_W-1:0]   HIGH_LATENCY_MS   = 20'd40;
    localparam logic [13:0]        MS_PER_DEPTH      = 14'd40;
    localparam logic [14:0]        MS_PER_DEPTH_M1   = 15'd39;
    // 52429 / 2^18 is just above 1/5, exact for every 12-bit dividend.
    localparam logic [15:0]        RECIP_5           = 16'd52429;

    localparam logic               RST_ENABLE       = 1'b1;
    localparam logic               RST_REJECT_STALE = 1'b1;
    localparam logic [TIME_W-1:0]  RST_MIN_WINDOW   = 32'd0;
    localparam logic [DEPTH_W-1:0] RST_MAX_DEPTH    = 8'd8;
    localparam logic [DEPTH_W-1:0] RST_DEPTH        = 8'd1;

    typedef enum logic [1:0] {
        REG_ENABLE       = 2'd0,
        REG_REJECT_STALE = 2'd1,
        REG_MIN_WINDOW   = 2'd2,
        REG_MAX_DEPTH    = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_ADJUST = 1'b1
    } req_type_t;

    typedef struct packed {
        logic               enable;
        logic               reject_stale;
        logic [TIME_W-1:0]  min_window_ms;
        logic [DEPTH_W-1:0] max_depth;
    } cfg_t;

    typedef struct packed {
        req_type_t          req_type;
        logic [RTT_W-1:0]   rtt_sample;
        logic [TIME_W-1:0]  now_ms;
    } item_t;

    typedef struct packed {
        logic [RTT_W-1:0]   avg_rtt;
        logic [RTT_W-1:0]   least_rtt;
        logic [TIME_W-1:0]  least_rtt_time;
        logic               latched_high;
        logic [DEPTH_W-1:0] cur_depth;
        logic [TIME_W-1:0]  last_adjust_time;
    } state_t;

    // ceil(x / 40) for x up to 40 * 255; only the low byte is meaningful there.
    function automatic logic [DEPTH_W-1:0] ceil_div40(input logic [13:0] x);
        logic [14:0] z;
        logic [11:0] w;
        logic [27:0] prod;
        z    = {1'b0, x} + MS_PER_DEPTH_M1;
        w    = z[14:3];
        prod = {16'd0, w} * {12'd0, RECIP_5};
        return prod[25:18];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rtt_aimd_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rtt_aimd_cfg (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_addr,
    input  wire logic [31:0]           cfg_wdata,
    output rtt_aimd_pkg::cfg_t         cfg
);

    rtt_aimd_pkg::cfg_t cfg_reg;
    rtt_aimd_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (rtt_aimd_pkg::cfg_reg_t'(cfg_addr))
                rtt_aimd_pkg::REG_ENABLE:       cfg_next.enable        = cfg_wdata[0];
                rtt_aimd_pkg::REG_REJECT_STALE: cfg_next.reject_stale  = cfg_wdata[0];
                rtt_aimd_pkg::REG_MIN_WINDOW:   cfg_next.min_window_ms = cfg_wdata;
                rtt_aimd_pkg::REG_MAX_DEPTH:    cfg_next.max_depth     = cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable        <= rtt_aimd_pkg::RST_ENABLE;
            cfg_reg.reject_stale  <= rtt_aimd_pkg::RST_REJECT_STALE;
            cfg_reg.min_window_ms <= rtt_aimd_pkg::RST_MIN_WINDOW;
            cfg_reg.max_depth     <= rtt_aimd_pkg::RST_MAX_DEPTH;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rtt_aimd_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rtt_aimd_calc (
    input  wire rtt_aimd_pkg::cfg_t    cfg,
    input  wire rtt_aimd_pkg::item_t   item,
    input  wire rtt_aimd_pkg::state_t  cur,
    output rtt_aimd_pkg::state_t       nxt,
    output logic                       accepted
);

    logic [21:0] rtt_plus1_x3;
    logic [21:0] avg_sum;
    logic        stale;
    logic [19:0] avg_new;
    logic [31:0] min_age;
    logic        min_replace;
    logic [31:0] adj_age;
    logic        heavy;
    logic [20:0] least_x15;
    logic [20:0] least_x125;
    logic [8:0]  d;
    logic [7:0]  maxd;
    logic [13:0] limit;
    logic [7:0]  hi;
    logic [7:0]  lo;

    always_comb begin
        nxt      = cur;
        accepted = 1'b1;

        // rtt < floor(avg / 3) holds exactly when 3 * (rtt + 1) <= avg.
        rtt_plus1_x3 = ({2'b00, item.rtt_sample} + 22'd1) * 22'd3;
        stale = cfg.reject_stale && (cur.avg_rtt != '0) &&
                (rtt_plus1_x3 <= {2'b00, cur.avg_rtt});
        avg_sum = {2'b00, cur.avg_rtt} * 22'd3 + {2'b00, item.rtt_sample};
        avg_new = (cur.avg_rtt != '0) ? avg_sum[21:2] : item.rtt_sample;
        min_age = item.now_ms - cur.least_rtt_time;
        min_replace = (cur.least_rtt == '0) || (item.rtt_sample <= cur.least_rtt) ||
                      ((cfg.min_window_ms != '0) && (min_age > cfg.min_window_ms));

        adj_age    = item.now_ms - cur.last_adjust_time;
        heavy      = {1'b0, cur.avg_rtt} > {cur.least_rtt, 1'b0};
        least_x15  = {1'b0, cur.least_rtt} + {2'b00, cur.least_rtt[19:1]};
        least_x125 = {1'b0, cur.least_rtt} + {3'b000, cur.least_rtt[19:2]};

        d = {1'b0, cur.cur_depth};
        if (heavy) begin
            if (d > 9'd1) begin
                d = d - 9'd1;
            end
        end else if (adj_age >= rtt_aimd_pkg::NUDGE_INTERVAL_MS) begin
            if ({1'b0, cur.avg_rtt} > least_x15) begin
                d = d - 9'd1;
            end else if ({1'b0, cur.avg_rtt} < least_x125) begin
                d = d + 9'd1;
            end
        end

        maxd  = (cfg.max_depth == '0) ? 8'd1 : cfg.max_depth;
        limit = {6'd0, maxd} * rtt_aimd_pkg::MS_PER_DEPTH;
        if (cur.least_rtt > {6'd0, limit}) begin
            hi = maxd;
        end else begin
            hi = rtt_aimd_pkg::ceil_div40(cur.least_rtt[13:0]);
        end
        if (cur.latched_high && (hi < 8'd2)) begin
            hi = 8'd2;
        end
        lo = cur.latched_high ? 8'd2 : 8'd1;
        if (lo > hi) begin
            lo = hi;
        end
        if (d > {1'b0, hi}) begin
            d = {1'b0, hi};
        end
        if (d < {1'b0, lo}) begin
            d = {1'b0, lo};
        end

        case (item.req_type)
            rtt_aimd_pkg::REQ_SAMPLE: begin
                if (stale) begin
                    accepted = 1'b0;
                end else begin
                    nxt.avg_rtt = avg_new;
                    if (avg_new > rtt_aimd_pkg::HIGH_LATENCY_MS) begin
                        nxt.latched_high = 1'b1;
                    end
                    if (min_replace) begin
                        nxt.least_rtt      = item.rtt_sample;
                        nxt.least_rtt_time = item.now_ms;
                    end
                end
            end
            rtt_aimd_pkg::REQ_ADJUST: begin
                // The dead band still restarts the nudge interval.
                if (cfg.enable && (cur.least_rtt != '0)) begin
                    nxt.cur_depth = d[7:0];
                    if (heavy || (adj_age >= rtt_aimd_pkg::NUDGE_INTERVAL_MS)) begin
                        nxt.last_adjust_time = item.now_ms;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/rtt_tracked_aimd_depth_control.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Beat contents
// s_        in         tuser: req_type; tdata: rtt_sample, now_ms
// m_        out        tuser: accepted; tdata: depth, smoothed_rtt, min_rtt, high_latency
// cfg_      in         cfg_addr: register index; cfg_wdata: value
//
// One beat is taken per cycle while the result side does not stall; a result passes
// through the input register and then the result register. The rate is set by the
// state update, which reads and writes the tracker registers between those two.
// Reset is synchronous; it restores the register defaults and a depth of one.
// A stalled result holds the input register, and s_tready drops once both are full.

module rtt_tracked_aimd_depth_control (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // [19:0] rtt_sample, [51:20] now_ms
    input  wire logic        s_tuser,   // [0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [7:0] depth, [27:8] smoothed_rtt,
                                        // [47:28] min_rtt, [48] high_latency
    output logic             m_tuser,   // [0] accepted
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata
);

    rtt_aimd_pkg::cfg_t   cfg;
    rtt_aimd_pkg::item_t  in_item_reg;
    rtt_aimd_pkg::state_t state_reg;
    rtt_aimd_pkg::state_t state_next;
    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [55:0]          m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 calc_accepted;
    logic                 advance;
    logic                 s_fire;

    rtt_aimd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rtt_aimd_calc u_calc (
        .cfg      (cfg),
        .item     (in_item_reg),
        .cur      (state_reg),
        .nxt      (state_next),
        .accepted (calc_accepted)
    );

    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_tvalid_next = m_tvalid_reg;
        if (advance) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg               <= 1'b0;
            m_tvalid_reg               <= 1'b0;
            state_reg.avg_rtt          <= '0;
            state_reg.least_rtt        <= '0;
            state_reg.least_rtt_time   <= '0;
            state_reg.latched_high     <= 1'b0;
            state_reg.cur_depth        <= rtt_aimd_pkg::RST_DEPTH;
            state_reg.last_adjust_time <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.req_type   <= rtt_aimd_pkg::req_type_t'(s_tuser);
            in_item_reg.rtt_sample <= s_tdata[19:0];
            in_item_reg.now_ms     <= s_tdata[51:20];
        end
        if (advance) begin
            m_tuser_reg <= calc_accepted;
            m_tdata_reg <= {7'd0, state_next.latched_high, state_next.least_rtt,
                            state_next.avg_rtt, state_next.cur_depth};
        end
    end

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("tracker state changed without an item moving to the result");

    a_depth_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.cur_depth != '0)
        else $error("depth reached zero");

    a_latch_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.latched_high |=> state_reg.latched_high)
        else $error("high-latency flag cleared outside reset");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid_reg)
        else $error("item left the input register without a result");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("pending item lost while the result side stalled");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  depth;
        logic [19:0] smoothed;
        logic [19:0] least;
        logic        high;
    } tracker_out_t;

    typedef struct packed {
        logic         used;
        tracker_out_t result;
    } pinned_t;

    // One row of the directed sweep; the pinned fields hold a hand-worked answer.
    typedef struct packed {
        rtt_aimd_pkg::req_type_t kind;
        logic [19:0] rtt;
        logic [31:0] now;
        logic        pinned;
        logic        w_acc;
        logic [7:0]  w_depth;
        logic [19:0] w_avg;
        logic [19:0] w_min;
        logic        w_high;
    } probe_t;

    typedef struct packed {
        logic        en;
        logic        rej;
        logic [31:0] win;
        logic [7:0]  maxd;
        logic        wrap;
        logic        quiet;
    } phase_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_addr  = '0;
    logic [31:0] cfg_wdata = '0;

    // Shadow copy of the depth controller.
    logic        enable_cfg     = rtt_aimd_pkg::RST_ENABLE;
    logic        reject_cfg     = rtt_aimd_pkg::RST_REJECT_STALE;
    logic [31:0] window_cfg     = rtt_aimd_pkg::RST_MIN_WINDOW;
    logic [7:0]  max_depth_cfg  = rtt_aimd_pkg::RST_MAX_DEPTH;
    logic [19:0] smoothed_ms    = '0;
    logic [19:0] floor_rtt_ms   = '0;
    logic [31:0] floor_rtt_at   = '0;
    logic        high_seen      = 1'b0;
    logic [7:0]  depth_now      = rtt_aimd_pkg::RST_DEPTH;
    logic [31:0] last_nudge_at  = '0;

    tracker_out_t pending_results[$];
    pinned_t      pinned_results[$];
    int unsigned  mismatches = 0;
    bit           steady     = 1'b0;
    logic [31:0]  clock_ms   = 32'd5000;

    probe_t probes [0:18] = '{
        '{rtt_aimd_pkg::REQ_ADJUST, 20'd0, 32'd0, 1'b1, 1'b1, 8'd1, 20'd0, 20'd0, 1'b0},
        '{rtt_aimd_pkg::REQ_SAMPLE, 20'd20, 32'd10, 1'b1, 1'b1, 8'd1, 20'd20, 20'd20, 1'b0},
        '{rtt_aimd_pkg::REQ_SAMPLE, 20'd0, 32'd15, 1'b1, 1'b0, 8'd1, 20'd20, 20'd20, 1'b0},
        '{rtt_aimd_pkg::REQ_ADJUST, 20'd0, 32'd20, 1'b0, 1'b0, 8'd0, 20'd0, 20'd0, 1'b0},
        '{rtt_aimd_pkg::REQ_ADJUST, 20'd0, 32'd400, 1'b0, 1'b0, 8'd0, 20'd0, 20'd0, 1'b0},
        '{rtt_aimd_pkg::REQ_SAMPLE, 20'd30, 32'd410, 1'b0, 1'b0, 8'd0, 20'd0, 20'd0, 1'b0},
        '{rtt_aimd_pkg::REQ_SAMPLE, 20'd40, 32'd420, 1'b0, 1'b0, 8'd0, 20'd0, 20'd0, 1'b0},
        '{rtt_aimd_pkg::REQ_ADJUST, 20'd0, 32'd900, 1'b0, 1'b0, 8'd0, 20'd0, 20'd0, 1'b0},
        '{rtt_aimd_pkg::REQ_SAMPLE, 20'd36, 32'd950, 1'b0, 1'b0, 8'd0, 20'd0, 20'd0, 1'b0},
        '{rtt_aimd_pkg::REQ_ADJUST, 20'd0, 32'd1000, 1'b0, 1'b0, 8'd0, 20'd0, 20'd0, 1'b0},
        '{rtt_aimd_pkg::REQ_SAMPLE, 20'hFFFFF, 32'hFFFFFFF0, 1'b0, 1'b0, 8'd0, 20'd0, 20'd0, 1'b0},
        '{rtt_aimd_pkg::REQ_ADJUST, 20'd0, 32'h00000010, 1'b0, 1'b0, 8'd0, 20'd0, 20'd0, 1'b0},
        '{rtt_aimd_pkg::REQ_SAMPLE, 20'd0, 32'h00000020, 1'b0, 1'b0, 8'd0, 20'd0, 20'd0, 1'b0},
        '{rtt_aimd_pkg::REQ_SAMPLE, 20'h55555, 32'hAAAAAAAA, 1'b0, 1'b0, 8'd0, 20'd0, 20'd0, 1'b0},
        '{rtt_aimd_pkg::REQ_ADJUST, 20'hAAAAA, 32'h55555555, 1'b0, 1'b0, 8'd0, 20'd0, 20'd0, 1'b0},
        '{rtt_aimd_pkg::REQ_SAMPLE, 20'hAAAAA, 32'h55555600, 1'b0, 1'b0, 8'd0, 20'd0, 20'd0, 1'b0},
        '{rtt_aimd_pkg::REQ_ADJUST, 20'd0, 32'hFFFFFFFF, 1'b0, 1'b0, 8'd0, 20'd0, 20'd0, 1'b0},
        '{rtt_aimd_pkg::REQ_SAMPLE, 20'd15, 32'h00001000, 1'b0, 1'b0, 8'd0, 20'd0, 20'd0, 1'b0},
        '{rtt_aimd_pkg::REQ_ADJUST, 20'd0, 32'h00002000, 1'b0, 1'b0, 8'd0, 20'd0, 20'd0, 1'b0}
    };

    phase_t plan [0:7] = '{
        '{1'b1, 1'b1, 32'd0,         8'd8,   1'b0, 1'b0},
        '{1'b1, 1'b1, 32'd500,       8'd255, 1'b1, 1'b0},
        '{1'b1, 1'b0, 32'd1,         8'd0,   1'b0, 1'b0},
        '{1'b0, 1'b1, 32'hFFFF_FFFF, 8'd1,   1'b0, 1'b0},
        '{1'b1, 1'b1, 32'd2000,      8'd4,   1'b0, 1'b1},
        '{1'b1, 1'b0, 32'd0,         8'd255, 1'b1, 1'b0},
        '{1'b1, 1'b1, 32'd300,       8'd16,  1'b0, 1'b0},
        '{1'b0, 1'b0, 32'd100,       8'd128, 1'b0, 1'b0}
    };

    rtt_tracked_aimd_depth_control DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [19:0] rtt_sample, [51:20] now_ms
        .s_tuser   (s_tuser),    // [0] req_type
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [7:0] depth, [27:8] smoothed_rtt,
                                 // [47:28] min_rtt, [48] high_latency
        .m_tuser   (m_tuser),    // [0] accepted
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 37);
    end

    // Advances the shadow tracker by one beat and returns what the block should report.
    function automatic tracker_out_t advance_tracker(input rtt_aimd_pkg::req_type_t kind,
                                                     input logic [19:0] rtt,
                                                     input logic [31:0] now);
        tracker_out_t r;
        logic [31:0]  avg32;
        logic [31:0]  min32;
        int           d;
        int           hi;
        int           lo;
        int           maxd;
        r.accepted = 1'b1;
        if (kind == rtt_aimd_pkg::REQ_SAMPLE) begin
            if (reject_cfg && smoothed_ms != 0 && rtt < smoothed_ms / 3) begin
                r.accepted = 1'b0;
            end else begin
                avg32 = {12'd0, smoothed_ms};
                smoothed_ms = (smoothed_ms != 0) ? 20'((avg32 * 32'd3 + {12'd0, rtt}) / 32'd4)
                                                 : rtt;
                if (smoothed_ms > 20'd40) begin
                    high_seen = 1'b1;
                end
                if (floor_rtt_ms == 0 || rtt <= floor_rtt_ms ||
                    (window_cfg != 0 && (now - floor_rtt_at) > window_cfg)) begin
                    floor_rtt_ms = rtt;
                    floor_rtt_at = now;
                end
            end
        end else if (enable_cfg && floor_rtt_ms != 0) begin
            avg32 = {12'd0, smoothed_ms};
            min32 = {12'd0, floor_rtt_ms};
            d = depth_now;
            if (avg32 > min32 * 2) begin
                // Heavy queuing cuts at once, regardless of the nudge interval.
                if (d > 1) begin
                    d--;
                end
                last_nudge_at = now;
            end else if (now - last_nudge_at >= 32'd400) begin
                last_nudge_at = now;
                if (avg32 > min32 + (min32 >> 1)) begin
                    d--;
                end else if (avg32 < min32 + (min32 >> 2)) begin
                    d++;
                end
            end
            maxd = (max_depth_cfg != 0) ? max_depth_cfg : 1;
            hi = (min32 + 32'd39) / 32'd40;
            if (hi > maxd) begin
                hi = maxd;
            end
            if (high_seen && hi < 2) begin
                hi = 2;
            end
            lo = high_seen ? 2 : 1;
            if (lo > hi) begin
                lo = hi;
            end
            if (d > hi) begin
                d = hi;
            end
            if (d < lo) begin
                d = lo;
            end
            depth_now = d[7:0];
        end
        r.depth    = depth_now;
        r.smoothed = smoothed_ms;
        r.least    = floor_rtt_ms;
        r.high     = high_seen;
        return r;
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : scoreboard
        tracker_out_t want;
        tracker_out_t got;
        pinned_t      pin;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want = advance_tracker(rtt_aimd_pkg::req_type_t'(s_tuser), s_tdata[19:0],
                                       s_tdata[51:20]);
                if (pinned_results.size() != 0) begin
                    pin = pinned_results.pop_front();
                    if (pin.used) begin
                        want = pin.result;
                    end
                end
                pending_results.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = '{m_tuser, m_tdata[7:0], m_tdata[27:8], m_tdata[47:28], m_tdata[48]};
                if (pending_results.size() == 0) begin
                    $error("result beat with no expectation pending");
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("accepted", want.accepted, got.accepted);
                    compare_field("depth", want.depth, got.depth);
                    compare_field("smoothed_rtt", want.smoothed, got.smoothed);
                    compare_field("min_rtt", want.least, got.least);
                    compare_field("high_latency", want.high, got.high);
                end
            end
        end
    end

    task automatic send_beat(input rtt_aimd_pkg::req_type_t kind, input logic [19:0] rtt,
                             input logic [31:0] now);
        while (!steady && $urandom_range(0, 99) < 37) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'd0, now, rtt};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
    endtask

    // Leaves cfg_valid high so back-to-back writes never toggle it within one step.
    task automatic write_reg(input rtt_aimd_pkg::cfg_reg_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            rtt_aimd_pkg::REG_ENABLE:       enable_cfg    = val[0];
            rtt_aimd_pkg::REG_REJECT_STALE: reject_cfg    = val[0];
            rtt_aimd_pkg::REG_MIN_WINDOW:   window_cfg    = val;
            rtt_aimd_pkg::REG_MAX_DEPTH:    max_depth_cfg = val[7:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_base();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, 40);
            1:       return $urandom_range(41, 400);
            2:       return $urandom_range(400, 12000);
            default: return $urandom_range(12000, 1048575);
        endcase
    endfunction

    initial begin : stimulus
        int          i;
        int          p;
        int          n;
        int unsigned roll;
        logic [31:0] base;
        logic [31:0] r32;
        rtt_aimd_pkg::req_type_t kind;
        logic [19:0] rtt;
        logic [31:0] now;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (i = 0; i < 19; i++) begin
            pinned_results.push_back('{probes[i].pinned,
                                       '{probes[i].w_acc, probes[i].w_depth, probes[i].w_avg,
                                         probes[i].w_min, probes[i].w_high}});
            send_beat(probes[i].kind, probes[i].rtt, probes[i].now);
        end

        for (p = 0; p < 8; p++) begin
            drain_results();
            write_reg(rtt_aimd_pkg::REG_ENABLE, {31'd0, plan[p].en});
            write_reg(rtt_aimd_pkg::REG_REJECT_STALE, {31'd0, plan[p].rej});
            write_reg(rtt_aimd_pkg::REG_MIN_WINDOW, plan[p].win);
            write_reg(rtt_aimd_pkg::REG_MAX_DEPTH, {24'd0, plan[p].maxd});
            cfg_valid <= 1'b0;
            steady = plan[p].quiet;
            if (plan[p].wrap) begin
                clock_ms = 32'hFFFF_F000 + $urandom_range(0, 4095);
            end
            base = pick_base();
            for (n = 0; n < 175; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    base = pick_base();
                end
                if ($urandom_range(0, 199) == 0) begin
                    drain_results();
                end
                if (roll < 10) begin
                    kind = rtt_aimd_pkg::req_type_t'($urandom_range(0, 1));
                    rtt  = 20'($urandom());
                    now  = $urandom();
                end else begin
                    // Realistic traffic: time moves forward and samples jitter around a base.
                    clock_ms += ($urandom_range(0, 9) == 0) ? $urandom_range(250, 1500)
                                                            : $urandom_range(0, 200);
                    now  = clock_ms;
                    kind = (roll < 55) ? rtt_aimd_pkg::REQ_SAMPLE : rtt_aimd_pkg::REQ_ADJUST;
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: r32 = base + $urandom_range(0, base / 2);
                        6, 7:             r32 = base * 2 + $urandom_range(0, base);
                        8:                r32 = base / 4;
                        default:          r32 = base;
                    endcase
                    rtt = (r32 > 32'hFFFFF) ? 20'hFFFFF : r32[19:0];
                end
                send_beat(kind, rtt, now);
            end
        end

        steady = 1'b0;
        drain_results();
        repeat (8) @(negedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
